// File: rtl/ptts_pkg.sv
// Shared types and codes for the periodic task tick scheduler
package ptts_pkg;

  // item kinds carried on s_tuser
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_PAUSE  = 3'd3,
    KIND_RESUME = 3'd4
  } kind_t;

  // per-slot run state
  typedef enum logic [1:0] {
    ST_DORMANT = 2'd0,
    ST_READY   = 2'd1,
    ST_PAUSED  = 2'd2
  } run_t;

  // field widths
  localparam int IdW     = 3;
  localparam int PeriodW = 16;
  localparam int DelayW  = 8;

  // controller state, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_CTRL  = 5'b10000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the input word
    logic rd;     // read slot tables at the walk index
    logic step;   // evaluate the slot, write back, advance
    logic flush;  // emit the closing result of a tick
    logic apply;  // apply a control item and emit its result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_tick;   // word on the input is a tick
    logic out_free;  // output register can take a word this cycle
    logic hold;      // evaluation must wait for the output register
    logic walk_end;  // walk index is on the last slot
  } stat_t;

endpackage

// File: rtl/ptts_ctrl.sv
// Sequencer for control items and the tick slot walk
module ptts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ptts_pkg::stat_t  stat,
  output ptts_pkg::cmd_t   cmd
);

  ptts_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ptts_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ptts_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = stat.in_tick ? ptts_pkg::S_READ : ptts_pkg::S_CTRL;
        end
      end
      ptts_pkg::S_READ: begin
        cmd.rd     = 1'b1;
        state_next = ptts_pkg::S_EVAL;
      end
      ptts_pkg::S_EVAL: begin
        if (!stat.hold) begin
          cmd.step   = 1'b1;
          state_next = stat.walk_end ? ptts_pkg::S_FLUSH : ptts_pkg::S_READ;
        end
      end
      ptts_pkg::S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ptts_pkg::S_IDLE;
        end
      end
      ptts_pkg::S_CTRL: begin
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ptts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ptts_dpath.sv
// Slot tables, countdown arithmetic and output register
module ptts_dpath #(
  parameter int TASK_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      s_tdata,
  input  logic [2:0]       s_tuser,
  input  ptts_pkg::cmd_t   cmd,
  output ptts_pkg::stat_t  stat,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // captured item
  logic [2:0]                    kind_q;
  logic [ptts_pkg::IdW-1:0]      id_q;
  logic [ptts_pkg::PeriodW-1:0]  per_q;
  logic [ptts_pkg::DelayW-1:0]   delay_q;

  // walk state
  logic [IW-1:0] idx;
  logic          pend_v;
  logic [IW-1:0] pend_idx;

  // slot flags, cleared by reset
  logic          used   [TASK_SLOTS];
  ptts_pkg::run_t rstate [TASK_SLOTS];

  // slot memories, not cleared; a free slot's value may be read but is not used
  logic [ptts_pkg::PeriodW-1:0] period_mem [TASK_SLOTS];
  logic [ptts_pkg::PeriodW-1:0] count_mem  [TASK_SLOTS];
  logic [ptts_pkg::PeriodW-1:0] rd_period;
  logic [ptts_pkg::PeriodW-1:0] rd_count;

  // output register
  logic       m_valid;
  logic [4:0] m_data;
  logic       m_last;

  logic                         tick_q;
  logic                         in_range;
  logic [IW-1:0]                addr;
  logic                         active;
  logic                         due;
  logic [ptts_pkg::PeriodW-1:0] new_count;
  logic                         create_ok;
  logic                         acc;
  logic                         out_free;
  logic                         emit;
  logic [4:0]                   emit_data;
  logic                         emit_last;

  assign tick_q   = (kind_q == ptts_pkg::KIND_TICK);
  assign in_range = ({4'b0, id_q} < 7'(TASK_SLOTS));
  // one address for flags and memories: walk index or addressed slot
  assign addr     = tick_q ? idx : IW'(id_q);
  assign out_free = !m_valid || m_tready;

  // slot evaluation during the walk
  assign active    = used[addr] && (rstate[addr] == ptts_pkg::ST_READY);
  assign due       = active && (rd_count == '0);
  assign new_count = due ? ((rd_period == '0) ? '0 : rd_period - 1'b1)
                         : rd_count - 1'b1;
  assign create_ok = in_range && !used[addr];

  // acceptance of a control item
  always_comb begin
    acc = 1'b0;
    case (kind_q)
      ptts_pkg::KIND_CREATE: acc = create_ok;
      ptts_pkg::KIND_DELETE,
      ptts_pkg::KIND_PAUSE,
      ptts_pkg::KIND_RESUME: acc = in_range;
      default:               acc = 1'b0;
    endcase
  end

  // status to controller
  assign stat.in_tick  = (s_tuser == ptts_pkg::KIND_TICK);
  assign stat.out_free = out_free;
  assign stat.hold     = due && pend_v && !out_free;
  assign stat.walk_end = (idx == IW'(TASK_SLOTS - 1));

  // result word selection: slot_id, due, accepted
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    emit_last = 1'b0;
    if (cmd.step && due && pend_v) begin
      emit      = 1'b1;
      emit_data = {1'b0, 1'b1, 3'(pend_idx)};
    end else if (cmd.flush) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      emit_data = pend_v ? {1'b0, 1'b1, 3'(pend_idx)} : 5'b0;
    end else if (cmd.apply) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      emit_data = {acc, 1'b0, id_q};
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= s_tuser;
      id_q    <= s_tdata[2:0];
      per_q   <= s_tdata[18:3];
      delay_q <= s_tdata[26:19];
    end
  end

  // walk index and pending due slot
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      pend_v <= 1'b0;
    end else if (cmd.load) begin
      idx    <= '0;
      pend_v <= 1'b0;
    end else if (cmd.step) begin
      if (!stat.walk_end) begin
        idx <= idx + 1'b1;
      end
      if (due) begin
        pend_v   <= 1'b1;
        pend_idx <= idx;
      end
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        used[i]   <= 1'b0;
        rstate[i] <= ptts_pkg::ST_DORMANT;
      end
    end else if (cmd.apply && in_range) begin
      case (kind_q)
        ptts_pkg::KIND_CREATE: begin
          if (create_ok) begin
            used[addr]   <= 1'b1;
            rstate[addr] <= ptts_pkg::ST_READY;
          end
        end
        ptts_pkg::KIND_DELETE: begin
          used[addr]   <= 1'b0;
          rstate[addr] <= ptts_pkg::ST_DORMANT;
        end
        ptts_pkg::KIND_PAUSE:  rstate[addr] <= ptts_pkg::ST_PAUSED;
        ptts_pkg::KIND_RESUME: rstate[addr] <= ptts_pkg::ST_READY;
        default: begin
        end
      endcase
    end
  end

  // period and countdown memories, one port each
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_period <= period_mem[addr];
      rd_count  <= count_mem[addr];
    end
    if (cmd.step && active) begin
      count_mem[addr] <= new_count;
    end else if (cmd.apply && kind_q == ptts_pkg::KIND_CREATE && create_ok) begin
      period_mem[addr] <= per_q;
      count_mem[addr]  <= {{(ptts_pkg::PeriodW - ptts_pkg::DelayW){1'b0}}, delay_q};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (emit) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_data <= emit_data;
      m_last <= emit_last;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {3'b0, m_data};
  assign m_tlast  = m_last;

endmodule

// File: rtl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler
// Control item: captured on acceptance, then applied and its result word registered
//   once the output register is free; no new item is taken until then.
// Tick: each slot is read from the tables, then evaluated and written back; a due
//   result can stall the walk at the output register, and a closing result ends it.
// Synchronous active-high reset frees all slots, makes them dormant and
//   empties the output register; period and countdown memories need no clearing.
module periodic_task_tick_scheduler #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // task_id[2:0], period[18:3], first_delay[26:19]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot_id[2:0], due[3], accepted[4]
  output logic        m_tlast
);

  ptts_pkg::cmd_t  cmd;
  ptts_pkg::stat_t stat;

  // sequencer
  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot tables and output
  ptts_dpath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/ptts_chk.sv
// Port-level checks for the periodic task tick scheduler and their bind
module ptts_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // a due result never reports acceptance
  a_due_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
    else $error("due and accepted both set");

  // a result without due always closes its item
  a_nodue_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> m_tlast)
    else $error("non-due result not marked last");

  // one item at a time: input closes after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // output register empty right after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind periodic_task_tick_scheduler ptts_chk u_ptts_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: test/periodic_task_tick_scheduler_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the periodic task tick scheduler
module periodic_task_tick_scheduler_test;

  localparam int SLOTS = 8;
  localparam int RANDOM_ITEMS = 324;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_AT = 150;
  localparam int HOLD_OFF_CYCLES = 500;
  // kinds the block does not know
  localparam logic [2:0] KIND_UNDEF_LO = 3'd5;
  localparam logic [2:0] KIND_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [ptts_pkg::IdW-1:0] slot_id;
    logic                     due;
    logic                     accepted;
    logic                     last;
  } sched_word_t;

  typedef struct {
    logic [2:0]                   kind;
    logic [ptts_pkg::IdW-1:0]     id;
    logic [ptts_pkg::PeriodW-1:0] per;
    logic [ptts_pkg::DelayW-1:0]  delay;
    bit                           fixed;
    sched_word_t                  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // task_id[2:0], period[18:3], first_delay[26:19]
  logic [2:0]  s_tuser = '0;   // kind[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // slot_id[2:0], due[3], accepted[4]
  logic        m_tlast;

  // shadow copy of the slot table
  logic                         busy [SLOTS];
  ptts_pkg::run_t               mode [SLOTS];
  logic [ptts_pkg::PeriodW-1:0] period_of [SLOTS];
  logic [ptts_pkg::PeriodW-1:0] count_left [SLOTS];

  sched_word_t pending_words [$];
  stim_row_t   directed [$];
  int          errors = 0;
  int          items_sent = 0;
  int          words_seen = 0;
  int          cycles = 0;

  periodic_task_tick_scheduler #(
    .TASK_SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("periodic_task_tick_scheduler_test NOT OK");
      $finish;
    end
  end

  // predict the words one input item causes and queue them
  function automatic void step_scheduler(input logic [2:0] kind,
                                         input logic [ptts_pkg::IdW-1:0] id,
                                         input logic [ptts_pkg::PeriodW-1:0] per,
                                         input logic [ptts_pkg::DelayW-1:0] delay);
    logic [SLOTS-1:0] due_mask;
    int               last_due;
    logic             acc;
    sched_word_t      w;
    if (kind == ptts_pkg::KIND_TICK) begin
      due_mask = '0;
      last_due = -1;
      // walk the slots, reload due ones and count down the rest
      for (int s = 0; s < SLOTS; s++) begin
        if (busy[s] && mode[s] == ptts_pkg::ST_READY) begin
          if (count_left[s] == '0) begin
            count_left[s] = (period_of[s] == '0) ? '0 : period_of[s] - 1'b1;
            due_mask[s] = 1'b1;
            last_due = s;
          end else begin
            count_left[s] = count_left[s] - 1'b1;
          end
        end
      end
      if (last_due < 0) begin
        w = '{slot_id: '0, due: 1'b0, accepted: 1'b0, last: 1'b1};
        pending_words.push_back(w);
      end else begin
        for (int s = 0; s < SLOTS; s++) begin
          if (due_mask[s]) begin
            w = '{slot_id: ptts_pkg::IdW'(s), due: 1'b1, accepted: 1'b0,
                  last: (s == last_due)};
            pending_words.push_back(w);
          end
        end
      end
    end else begin
      acc = 1'b0;
      case (kind)
        ptts_pkg::KIND_CREATE: begin
          if (!busy[id]) begin
            period_of[id] = per;
            count_left[id] = ptts_pkg::PeriodW'(delay);
            busy[id] = 1'b1;
            mode[id] = ptts_pkg::ST_READY;
            acc = 1'b1;
          end
        end
        ptts_pkg::KIND_DELETE: begin
          busy[id] = 1'b0;
          mode[id] = ptts_pkg::ST_DORMANT;
          acc = 1'b1;
        end
        ptts_pkg::KIND_PAUSE: begin
          mode[id] = ptts_pkg::ST_PAUSED;
          acc = 1'b1;
        end
        ptts_pkg::KIND_RESUME: begin
          mode[id] = ptts_pkg::ST_READY;
          acc = 1'b1;
        end
        default: ;
      endcase
      w = '{slot_id: id, due: 1'b0, accepted: acc, last: 1'b1};
      pending_words.push_back(w);
    end
  endfunction

  // present one word on the input and wait for it to be taken
  task automatic offer_word(input logic [2:0] kind, input logic [ptts_pkg::IdW-1:0] id,
                            input logic [ptts_pkg::PeriodW-1:0] per,
                            input logic [ptts_pkg::DelayW-1:0] delay);
    int gap;
    gap = (items_sent % 64 < 16) ? 0 : $urandom_range(8);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'b0, delay, per, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    step_scheduler(kind, id, per, delay);
  endtask

  task automatic add_row(input logic [2:0] kind, input logic [ptts_pkg::IdW-1:0] id,
                         input logic [ptts_pkg::PeriodW-1:0] per,
                         input logic [ptts_pkg::DelayW-1:0] delay,
                         input bit fixed, input logic [ptts_pkg::IdW-1:0] slot,
                         input logic due, input logic acc);
    stim_row_t r;
    r.kind = kind;
    r.id = id;
    r.per = per;
    r.delay = delay;
    r.fixed = fixed;
    r.want = '{slot_id: slot, due: due, accepted: acc, last: 1'b1};
    directed.push_back(r);
  endtask

  // compare one output word with the oldest prediction
  task automatic check_word(input logic [7:0] data, input logic tlast);
    sched_word_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: word with nothing pending: slot %0d due %0b accepted %0b last %0b",
               $time, data[2:0], data[3], data[4], tlast);
      errors++;
    end else begin
      want = pending_words.pop_front();
      if (data[2:0] !== want.slot_id) begin
        $display("%0t: slot_id expected %0d got %0d", $time, want.slot_id, data[2:0]);
        errors++;
      end
      if (data[3] !== want.due) begin
        $display("%0t: due expected %0b got %0b", $time, want.due, data[3]);
        errors++;
      end
      if (data[4] !== want.accepted) begin
        $display("%0t: accepted expected %0b got %0b", $time, want.accepted, data[4]);
        errors++;
      end
      if (tlast !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, tlast);
        errors++;
      end
    end
  endtask

  // output side: random stalls, one long hold-off to back the block up
  initial begin : drain_side
    int stall;
    wait (!rst);
    forever begin
      if (words_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      else stall = (words_seen % 50 < 12) ? 0 : $urandom_range(8);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_word(m_tdata, m_tlast);
      words_seen++;
    end
  end

  // stimulus and verdict
  initial begin : feed_side
    logic [2:0]                   kind;
    logic [ptts_pkg::IdW-1:0]     id;
    logic [ptts_pkg::PeriodW-1:0] per;
    logic [ptts_pkg::DelayW-1:0]  delay;
    int                           pick;
    for (int s = 0; s < SLOTS; s++) begin
      busy[s] = 1'b0;
      mode[s] = ptts_pkg::ST_DORMANT;
      period_of[s] = '0;
      count_left[s] = '0;
    end

    // fresh table: nothing due, pause and resume act on free slots
    add_row(ptts_pkg::KIND_TICK, 0, 0, 0, 1, 0, 0, 0);
    add_row(ptts_pkg::KIND_PAUSE, 3, 0, 0, 1, 3, 0, 1);
    add_row(ptts_pkg::KIND_RESUME, 5, 16'hFFFF, 8'hFF, 1, 5, 0, 1);
    add_row(ptts_pkg::KIND_TICK, 7, 16'hFFFF, 8'hFF, 1, 0, 0, 0);
    // zero period, widest period and delay, create on an occupied slot
    add_row(ptts_pkg::KIND_CREATE, 0, 0, 0, 1, 0, 0, 1);
    add_row(ptts_pkg::KIND_CREATE, 7, 16'hFFFF, 8'hFF, 1, 7, 0, 1);
    add_row(ptts_pkg::KIND_CREATE, 0, 16'h1234, 8'h5A, 1, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 2, 1, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 4, 3, 1, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 5, 2, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0);
    // paused slot skipped, then resumed
    add_row(ptts_pkg::KIND_PAUSE, 2, 0, 0, 1, 2, 0, 1);
    add_row(ptts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_RESUME, 2, 0, 0, 1, 2, 0, 1);
    // delete of a used and of a free slot, unknown kinds
    add_row(ptts_pkg::KIND_DELETE, 0, 0, 0, 1, 0, 0, 1);
    add_row(ptts_pkg::KIND_DELETE, 6, 0, 0, 1, 6, 0, 1);
    add_row(KIND_UNDEF_LO, 1, 16'hFFFF, 8'hFF, 1, 1, 0, 0);
    add_row(KIND_UNDEF_HI, 6, 16'hAAAA, 8'h55, 1, 6, 0, 0);
    // fill the free slots with zero period so every slot is used and those are due
    add_row(ptts_pkg::KIND_DELETE, 7, 0, 0, 1, 7, 0, 1);
    add_row(ptts_pkg::KIND_CREATE, 7, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 1, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 3, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 6, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_CREATE, 0, 0, 0, 0, 0, 0, 0);
    add_row(ptts_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer_word(directed[i].kind, directed[i].id, directed[i].per, directed[i].delay);
      // a typed row replaces the single predicted word
      if (directed[i].fixed) begin
        void'(pending_words.pop_back());
        pending_words.push_back(directed[i].want);
      end
    end

    // random mix, mostly ticks and creates with short periods
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) kind = ptts_pkg::KIND_TICK;
      else if (pick < 70) kind = ptts_pkg::KIND_CREATE;
      else if (pick < 80) kind = ptts_pkg::KIND_DELETE;
      else if (pick < 88) kind = ptts_pkg::KIND_PAUSE;
      else if (pick < 96) kind = ptts_pkg::KIND_RESUME;
      else kind = 3'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO));
      id = ptts_pkg::IdW'($urandom_range(SLOTS - 1));
      per = ($urandom_range(7) == 0) ? ptts_pkg::PeriodW'($urandom_range(16'hFFFF))
                                     : ptts_pkg::PeriodW'($urandom_range(4));
      delay = ($urandom_range(7) == 0) ? ptts_pkg::DelayW'($urandom_range(8'hFF))
                                       : ptts_pkg::DelayW'($urandom_range(4));
      offer_word(kind, id, per, delay);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("periodic_task_tick_scheduler_test OK");
    else $display("periodic_task_tick_scheduler_test NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ptts_pkg.sv
rtl/ptts_ctrl.sv
rtl/ptts_dpath.sv
rtl/periodic_task_tick_scheduler.sv
rtl/ptts_chk.sv
test/periodic_task_tick_scheduler_test.sv
